>>> src/ipid_pkg.sv
`default_nettype none

package ipid_pkg;

	// Width of the error, position, gain and limit fields.
	localparam int DATA_W = 16;

	// Width of the drive result.
	localparam int DRIVE_W = 34;

	// Width of the configuration register index.
	localparam int CFG_INDEX_W = 4;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_PROP_NUM  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PROP_DEN  = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INTEG_NUM = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_INTEG_DEN = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DERIV_NUM = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_DERIV_DEN = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_UPPER_LIM = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_LOWER_LIM = 4'd7;

	// Reset values of the configuration registers.
	localparam int PROP_NUM_RST  = 1;
	localparam int PROP_DEN_RST  = 30;
	localparam int INTEG_NUM_RST = 1;
	localparam int INTEG_DEN_RST = 30;
	localparam int DERIV_NUM_RST = 0;
	localparam int DERIV_DEN_RST = 1;
	localparam int UPPER_LIM_RST = 15;
	localparam int LOWER_LIM_RST = -15;

	// Input transaction.
	typedef struct packed {
		logic signed [DATA_W-1:0] error_value;
		logic signed [DATA_W-1:0] measured_position;
	} sample_t;

	// Output transaction.
	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive_value;
		logic                      gain_invalid;
	} result_t;

	// Term currently being worked on.
	typedef enum logic [1:0] {
		TERM_P = 2'd0,
		TERM_I = 2'd1,
		TERM_D = 2'd2
	} term_t;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOAD = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_ADD  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

endpackage

`default_nettype wire

>>> src/integer_pid_step_core.sv
`default_nettype none
// Each term runs through operand load, a one-bit-per-cycle shift-add multiply, a
// one-bit-per-cycle restoring divide and accumulate, for the P, I and D terms in turn.
// A new input transaction is taken only once the previous result has entered the output
// register, since the single shared bit-serial multiply/divide datapath serves all terms;
// with a zero denominator the multiply and divide are skipped.
// Reset: asynchronous, active low; gains and limits return to their defaults, state to zero.
module integer_pid_step_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 sample_valid,
	output      logic                                 sample_stall,
	input  wire ipid_pkg::sample_t                    sample,
	output      logic                                 result_valid,
	input  wire logic                                 result_stall,
	output      ipid_pkg::result_t                    result,
	input  wire logic                                 cfg_valid,
	output      logic                                 cfg_ready,
	input  wire logic [ipid_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [ipid_pkg::DATA_W-1:0]          cfg_data
);

	localparam int W     = ipid_pkg::DATA_W;
	localparam int DW    = ipid_pkg::DRIVE_W;
	localparam int CNT_W = $clog2(2 * W);
	localparam int EXT_W = (2 * W > DW) ? 2 * W : DW;

	// Configuration registers.
	logic [W-1:0] prop_num_q, prop_den_q, integ_num_q, integ_den_q;
	logic [W-1:0] deriv_num_q, deriv_den_q, upper_lim_q, lower_lim_q;

	// Controller state and per-transaction operands.
	logic [W-1:0] integ_q, last_pos_q, err_q;
	logic [W:0]   diff_q;

	// Sequencer and bit-serial datapath.
	ipid_pkg::state_t state_q;
	ipid_pkg::term_t  term_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2*W-1:0]   work_q;
	logic [W-1:0]     mcand_q;
	logic [W-1:0]     rem_q;
	logic             neg_q;
	logic [DW-1:0]    sum_q;
	logic             invalid_q;

	// Output register.
	ipid_pkg::result_t result_q;
	logic              result_valid_q;

	logic         accept;
	logic         any_den_zero;
	logic signed [W:0] acc_sum, up_ext, lo_ext;
	logic [W-1:0] integ_next;
	logic [W:0]   a_sel;
	logic [W-1:0] b_sel, den_sel;
	logic [W:0]   a_neg;
	logic [W-1:0] a_mag, b_mag, den_mag;
	logic [W:0]   mul_hi;
	logic [W:0]   rem_sh;
	logic [W+1:0] trial;
	logic         q_bit;
	logic [EXT_W-1:0] q_wide;
	logic [DW-1:0]    q_term;
	logic         out_free;

	assign cfg_ready    = 1'b1;
	assign sample_stall = (state_q != ipid_pkg::ST_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || !result_stall;

	assign any_den_zero = (prop_den_q == '0) || (integ_den_q == '0) || (deriv_den_q == '0);

	// Integrator update with the upper limit tested first.
	always_comb begin
		acc_sum = $signed({integ_q[W-1], integ_q}) +
			$signed({sample.error_value[W-1], sample.error_value});
		up_ext  = $signed({upper_lim_q[W-1], upper_lim_q});
		lo_ext  = $signed({lower_lim_q[W-1], lower_lim_q});
		if (acc_sum > up_ext) begin
			integ_next = upper_lim_q;
		end else if (acc_sum < lo_ext) begin
			integ_next = lower_lim_q;
		end else begin
			integ_next = acc_sum[W-1:0];
		end
	end

	// Operand selection for the current term.
	always_comb begin
		unique case (term_q)
			ipid_pkg::TERM_P: begin
				a_sel   = {err_q[W-1], err_q};
				b_sel   = prop_num_q;
				den_sel = prop_den_q;
			end
			ipid_pkg::TERM_I: begin
				a_sel   = {integ_q[W-1], integ_q};
				b_sel   = integ_num_q;
				den_sel = integ_den_q;
			end
			ipid_pkg::TERM_D: begin
				a_sel   = diff_q;
				b_sel   = deriv_num_q;
				den_sel = deriv_den_q;
			end
			default: begin
				a_sel   = '0;
				b_sel   = '0;
				den_sel = '0;
			end
		endcase
	end

	// Magnitudes; every magnitude fits W unsigned bits.
	always_comb begin
		a_neg   = -a_sel;
		a_mag   = a_sel[W] ? a_neg[W-1:0] : a_sel[W-1:0];
		b_mag   = b_sel[W-1] ? -b_sel : b_sel;
		den_mag = den_sel[W-1] ? -den_sel : den_sel;
	end

	// One shift-add multiply step and one restoring divide step.
	always_comb begin
		mul_hi = {1'b0, work_q[2*W-1:W]} + {1'b0, mcand_q};
		rem_sh = {rem_q, work_q[2*W-1]};
		trial  = {1'b0, rem_sh} - {2'b00, den_mag};
		q_bit  = !trial[W+1];
	end

	// Signed quotient folded to the drive width.
	always_comb begin
		q_wide = EXT_W'(work_q);
		q_term = neg_q ? -q_wide[DW-1:0] : q_wide[DW-1:0];
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_num_q  <= W'(ipid_pkg::PROP_NUM_RST);
			prop_den_q  <= W'(ipid_pkg::PROP_DEN_RST);
			integ_num_q <= W'(ipid_pkg::INTEG_NUM_RST);
			integ_den_q <= W'(ipid_pkg::INTEG_DEN_RST);
			deriv_num_q <= W'(ipid_pkg::DERIV_NUM_RST);
			deriv_den_q <= W'(ipid_pkg::DERIV_DEN_RST);
			upper_lim_q <= W'(ipid_pkg::UPPER_LIM_RST);
			lower_lim_q <= W'(ipid_pkg::LOWER_LIM_RST);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ipid_pkg::REG_PROP_NUM:  prop_num_q  <= cfg_data;
				ipid_pkg::REG_PROP_DEN:  prop_den_q  <= cfg_data;
				ipid_pkg::REG_INTEG_NUM: integ_num_q <= cfg_data;
				ipid_pkg::REG_INTEG_DEN: integ_den_q <= cfg_data;
				ipid_pkg::REG_DERIV_NUM: deriv_num_q <= cfg_data;
				ipid_pkg::REG_DERIV_DEN: deriv_den_q <= cfg_data;
				ipid_pkg::REG_UPPER_LIM: upper_lim_q <= cfg_data;
				ipid_pkg::REG_LOWER_LIM: lower_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Controller state is updated as the transaction is taken, unless a gain is invalid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			last_pos_q <= '0;
		end else if (accept && !any_den_zero) begin
			integ_q    <= integ_next;
			last_pos_q <= sample.measured_position;
		end
	end

	// Operands captured with the transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q  <= sample.error_value;
			diff_q <= {last_pos_q[W-1], last_pos_q} -
				{sample.measured_position[W-1], sample.measured_position};
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ipid_pkg::ST_IDLE;
			term_q    <= ipid_pkg::TERM_P;
			cnt_q     <= '0;
			sum_q     <= '0;
			invalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ipid_pkg::ST_IDLE: begin
					if (accept) begin
						sum_q     <= '0;
						term_q    <= ipid_pkg::TERM_P;
						invalid_q <= any_den_zero;
						state_q   <= any_den_zero ? ipid_pkg::ST_FIN : ipid_pkg::ST_LOAD;
					end
				end
				ipid_pkg::ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ipid_pkg::ST_MUL;
				end
				ipid_pkg::ST_MUL: begin
					if (cnt_q == CNT_W'(W - 1)) begin
						cnt_q   <= '0;
						state_q <= ipid_pkg::ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ipid_pkg::ST_DIV: begin
					if (cnt_q == CNT_W'(2 * W - 1)) begin
						cnt_q   <= '0;
						state_q <= ipid_pkg::ST_ADD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ipid_pkg::ST_ADD: begin
					sum_q <= sum_q + q_term;
					unique case (term_q)
						ipid_pkg::TERM_P: begin
							term_q  <= ipid_pkg::TERM_I;
							state_q <= ipid_pkg::ST_LOAD;
						end
						ipid_pkg::TERM_I: begin
							term_q  <= ipid_pkg::TERM_D;
							state_q <= ipid_pkg::ST_LOAD;
						end
						default: begin
							state_q <= ipid_pkg::ST_FIN;
						end
					endcase
				end
				ipid_pkg::ST_FIN: begin
					if (out_free) begin
						state_q <= ipid_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= ipid_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Bit-serial datapath: the product builds up in work_q and is then
	// replaced, bit by bit, by the quotient.
	always_ff @(posedge clk) begin
		if (state_q == ipid_pkg::ST_LOAD) begin
			work_q  <= {{W{1'b0}}, b_mag};
			mcand_q <= a_mag;
			rem_q   <= '0;
			neg_q   <= a_sel[W] ^ b_sel[W-1] ^ den_sel[W-1];
		end else if (state_q == ipid_pkg::ST_MUL) begin
			if (work_q[0]) begin
				work_q <= {mul_hi, work_q[W-1:1]};
			end else begin
				work_q <= {1'b0, work_q[2*W-1:1]};
			end
		end else if (state_q == ipid_pkg::ST_DIV) begin
			rem_q  <= q_bit ? trial[W-1:0] : rem_sh[W-1:0];
			work_q <= {work_q[2*W-2:0], q_bit};
		end
	end

	// Output register; a finished result waits here while the next transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ipid_pkg::ST_FIN && out_free) begin
			result_valid_q <= 1'b1;
		end else if (result_valid_q && !result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ipid_pkg::ST_FIN && out_free) begin
			result_q.drive_value  <= invalid_q ? '0 : sum_q;
			result_q.gain_invalid <= invalid_q;
		end
	end

endmodule

`default_nettype wire

>>> bench/tb_integer_pid_step_core.sv
`timescale 1ns / 1ps

module tb_integer_pid_step_core;
	import ipid_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   sample_valid;
	logic                   sample_stall;
	sample_t                sample;
	logic                   result_valid;
	logic                   result_stall;
	result_t                result;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [DATA_W-1:0]      cfg_data;

	// Shadow copy of the gains, limits and controller state.
	logic signed [DATA_W-1:0] prop_num, prop_den;
	logic signed [DATA_W-1:0] integ_num, integ_den;
	logic signed [DATA_W-1:0] deriv_num, deriv_den;
	logic signed [DATA_W-1:0] upper_lim, lower_lim;
	logic signed [DATA_W-1:0] integ_state, last_pos;

	// Drive values still to come out of the block, oldest first.
	result_t drive_expected[$];
	int      mismatch_count;
	bit      no_idle;

	integer_pid_step_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Clock generation.
	always #5 clk = ~clk;

	// Decide whether a side sits out the current cycle.
	function automatic bit take_break();
		return !no_idle && ($urandom_range(99) < 37);
	endfunction

	// Work out the controller output for one sample and advance the shadow state.
	function automatic result_t predict_drive(sample_t s);
		longint  err, pos, p_term, i_term, d_term, acc;
		result_t r;
		err = longint'($signed(s.error_value));
		pos = longint'($signed(s.measured_position));
		r.drive_value  = '0;
		r.gain_invalid = 1'b1;
		// A zero denominator forces the output to zero and freezes the state.
		if (prop_den == 0 || integ_den == 0 || deriv_den == 0) begin
			return r;
		end
		p_term = (err * prop_num) / prop_den;
		// The upper clamp is tested before the lower one, even if they cross.
		acc = longint'(integ_state) + err;
		if (acc > upper_lim) begin
			acc = upper_lim;
		end else if (acc < lower_lim) begin
			acc = lower_lim;
		end
		integ_state = DATA_W'(acc);
		i_term = (longint'(integ_state) * integ_num) / integ_den;
		// Derivative on measurement: last position minus the current one.
		d_term = ((longint'(last_pos) - pos) * deriv_num) / deriv_den;
		last_pos = s.measured_position;
		r.drive_value  = DRIVE_W'(p_term + i_term + d_term);
		r.gain_invalid = 1'b0;
		return r;
	endfunction

	// Send one sample; valid stays high on return so that transactions can run back to back.
	task automatic send_sample(input logic [DATA_W-1:0] err, input logic [DATA_W-1:0] pos);
		sample_t s;
		s.error_value       = err;
		s.measured_position = pos;
		while (take_break()) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (sample_stall);
		drive_expected.push_back(predict_drive(s));
	endtask

	// Stop sending and wait until the block has delivered everything and gone idle.
	task automatic wait_idle();
		sample_valid <= 1'b0;
		while (drive_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Write one configuration register and mirror it in the shadow copy.
	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PROP_NUM:  prop_num  = value;
			REG_PROP_DEN:  prop_den  = value;
			REG_INTEG_NUM: integ_num = value;
			REG_INTEG_DEN: integ_den = value;
			REG_DERIV_NUM: deriv_num = value;
			REG_DERIV_DEN: deriv_den = value;
			REG_UPPER_LIM: upper_lim = value;
			REG_LOWER_LIM: lower_lim = value;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Write the complete register set.
	task automatic configure(input int pn, input int pd, input int in_, input int id,
			input int dn, input int dd, input int up, input int lo);
		write_register(REG_PROP_NUM,  DATA_W'(pn));
		write_register(REG_PROP_DEN,  DATA_W'(pd));
		write_register(REG_INTEG_NUM, DATA_W'(in_));
		write_register(REG_INTEG_DEN, DATA_W'(id));
		write_register(REG_DERIV_NUM, DATA_W'(dn));
		write_register(REG_DERIV_DEN, DATA_W'(dd));
		write_register(REG_UPPER_LIM, DATA_W'(up));
		write_register(REG_LOWER_LIM, DATA_W'(lo));
	endtask

	// Random word biased towards the extremes and towards small magnitudes.
	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(9))
			0: return {1'b1, {(DATA_W-1){1'b0}}};
			1: return {1'b0, {(DATA_W-1){1'b1}}};
			2, 3: return DATA_W'($urandom_range(128)) - DATA_W'(64);
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// Random denominator, zero only now and then.
	function automatic logic [DATA_W-1:0] rand_den();
		logic [DATA_W-1:0] v;
		v = rand_word();
		if (v == 0 && $urandom_range(4) != 0) begin
			v = 1;
		end
		return v;
	endfunction

	// Directed items at the reset gains: extremes and integrator saturation.
	task automatic test_reset_defaults();
		send_sample(16'd0, 16'd0);
		send_sample(16'h7fff, 16'h7fff);
		send_sample(16'h8000, 16'h8000);
		send_sample(16'd5, 16'd100);
		send_sample(16'hfffd, 16'hff9c);
		wait_idle();
	endtask

	// Directed items with the gains and limits at their extremes.
	task automatic test_extreme_gains();
		configure(-32768, 1, 32767, -1, 32767, -32768, 32767, -32768);
		send_sample(16'h7fff, 16'h8000);
		send_sample(16'h8000, 16'h7fff);
		send_sample(16'h8000, 16'h7fff);
		send_sample(16'hffff, 16'hffff);
		wait_idle();
	endtask

	// Lower limit above the upper one: the upper test still wins.
	task automatic test_crossed_limits();
		configure(3, 1, 1, 1, -2, 1, -100, 100);
		send_sample(16'd0, 16'd10);
		send_sample(16'd500, 16'hfff6);
		send_sample(16'hfe0c, 16'd0);
		wait_idle();
	endtask

	// Each denominator at zero in turn, then a check that the state was held.
	task automatic test_zero_denominators();
		configure(7, 3, -5, 2, 4, -3, 200, -200);
		send_sample(16'd50, 16'd20);
		wait_idle();
		write_register(REG_PROP_DEN, '0);
		send_sample(16'd90, 16'd1000);
		wait_idle();
		write_register(REG_PROP_DEN, 16'd3);
		write_register(REG_INTEG_DEN, '0);
		send_sample(16'h8000, 16'h7fff);
		wait_idle();
		write_register(REG_INTEG_DEN, 16'd2);
		write_register(REG_DERIV_DEN, '0);
		send_sample(16'h7fff, 16'h8000);
		wait_idle();
		write_register(REG_DERIV_DEN, 16'hfffd);
		send_sample(16'd10, 16'd25);
		wait_idle();
	endtask

	// Writes to indexes beyond the register set must leave every gain alone.
	task automatic test_unused_indexes();
		write_register(4'd8, 16'h0000);
		write_register(4'd15, 16'hffff);
		write_register(4'd10, 16'h5a5a);
		send_sample(16'hffe0, 16'd77);
		wait_idle();
	endtask

	// A long run with neither side idling.
	task automatic test_steady_stream();
		no_idle = 1'b1;
		repeat (130) send_sample(rand_word(), rand_word());
		wait_idle();
		no_idle = 1'b0;
	endtask

	// Random register settings, each followed by a batch of random samples.
	task automatic test_random_settings();
		repeat (10) begin
			write_register(REG_PROP_NUM,  rand_word());
			write_register(REG_PROP_DEN,  rand_den());
			write_register(REG_INTEG_NUM, rand_word());
			write_register(REG_INTEG_DEN, rand_den());
			write_register(REG_DERIV_NUM, rand_word());
			write_register(REG_DERIV_DEN, rand_den());
			write_register(REG_UPPER_LIM, rand_word());
			write_register(REG_LOWER_LIM, rand_word());
			if ($urandom_range(2) == 0) begin
				write_register(CFG_INDEX_W'($urandom_range(15, 8)), DATA_W'($urandom));
			end
			repeat (120) send_sample(rand_word(), rand_word());
			wait_idle();
		end
	endtask

	// Result checker and receiver stall.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (drive_expected.size() == 0) begin
					$error("result transaction with nothing expected: drive_value %0d",
						result.drive_value);
					mismatch_count++;
				end else begin
					want = drive_expected.pop_front();
					if (result.drive_value !== want.drive_value) begin
						$error("drive_value: expected %0d, actual %0d",
							want.drive_value, result.drive_value);
						mismatch_count++;
					end
					if (result.gain_invalid !== want.gain_invalid) begin
						$error("gain_invalid: expected %0b, actual %0b",
							want.gain_invalid, result.gain_invalid);
						mismatch_count++;
					end
				end
			end
			result_stall <= take_break();
		end
	end

	// Overall time limit.
	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Main sequence.
	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		sample_valid   = 1'b0;
		sample         = '0;
		result_stall   = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		no_idle        = 1'b0;
		mismatch_count = 0;
		prop_num       = DATA_W'(PROP_NUM_RST);
		prop_den       = DATA_W'(PROP_DEN_RST);
		integ_num      = DATA_W'(INTEG_NUM_RST);
		integ_den      = DATA_W'(INTEG_DEN_RST);
		deriv_num      = DATA_W'(DERIV_NUM_RST);
		deriv_den      = DATA_W'(DERIV_DEN_RST);
		upper_lim      = DATA_W'(UPPER_LIM_RST);
		lower_lim      = DATA_W'(LOWER_LIM_RST);
		integ_state    = '0;
		last_pos       = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_extreme_gains();
		test_crossed_limits();
		test_zero_denominators();
		test_unused_indexes();
		test_steady_stream();
		test_random_settings();

		// Allow for any stray result after the last expected one.
		wait_idle();
		repeat (200) @(posedge clk);
		if (drive_expected.size() != 0) begin
			$error("%0d expected results never arrived", drive_expected.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
